>>> design/mte_pkg.sv
// Shared types and constants for the multi-turn encoder tracker.
// No dependencies; every other design file imports this package.
package mte_pkg;

    localparam int ANGLE_BITS_DEF = 12;
    localparam int TURN_BITS_DEF  = 16;
    localparam int STATUS_W       = 6;
    localparam int FRAME_W        = 18;
    localparam int DATA_W         = 32;
    localparam int GAIN_W         = 24;
    localparam int GAIN_FRAC      = 16;
    localparam int WRAP_W         = 12;
    localparam int OUT_ANGLE_W    = 12;
    localparam int OUT_TURNS_W    = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_ADDR_W     = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET      = 24'd65536;
    localparam logic [WRAP_W-1:0] WRAP_HIGH_RESET = 12'd3900;
    localparam logic [WRAP_W-1:0] WRAP_LOW_RESET  = 12'd195;

    localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] POS_MIN = 32'h8000_0000;

    // Item commands.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN      = 2'd0,
        CFG_WRAP_HIGH = 2'd1,
        CFG_WRAP_LOW  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [WRAP_W-1:0] wrap_high;
        logic [WRAP_W-1:0] wrap_low;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> design/mte_front.sv
// Front end of the encoder tracker: accepts items, unwraps the angle into a turn count.
// Depends on mte_pkg; feeds mte_queue.
module mte_front import mte_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int TURN_BITS  = TURN_BITS_DEF,
    localparam int ENTRY_W   = 1 + ANGLE_BITS + TURN_BITS + STATUS_W + DATA_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic [DATA_W-1:0]  i_desired,
    input  t_q_stat            i_q_stat,
    output logic               o_ready,
    output logic               o_push,
    output logic [ENTRY_W-1:0] o_entry
);

    localparam int CMP_W = (ANGLE_BITS > WRAP_W) ? ANGLE_BITS : WRAP_W;
    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    logic [ANGLE_BITS-1:0]       r_last_angle, n_last_angle;
    logic                        r_primed, n_primed;
    logic signed [TURN_BITS-1:0] r_turns, n_turns;
    logic [STATUS_W-1:0]         r_status, n_status;

    logic [FRAME_W-1:0]    w_shift;
    logic [ANGLE_BITS-1:0] w_angle;
    logic                  w_accept, w_wrap_up, w_wrap_dn;

    assign w_shift  = i_frame >> STATUS_W;
    assign w_angle  = ANGLE_BITS'(w_shift);
    assign w_accept = i_valid && !i_q_stat.full;

    // Wrap detection: previous sample near the top and new one near zero, or the reverse.
    assign w_wrap_up = (CMP_W'(r_last_angle) > CMP_W'(i_cfg.wrap_high)) &&
                       (CMP_W'(w_angle) < CMP_W'(i_cfg.wrap_low));
    assign w_wrap_dn = (CMP_W'(r_last_angle) < CMP_W'(i_cfg.wrap_low)) &&
                       (CMP_W'(w_angle) > CMP_W'(i_cfg.wrap_high));

    always_comb begin
        n_last_angle = r_last_angle;
        n_primed     = r_primed;
        n_turns      = r_turns;
        n_status     = r_status;
        case (i_cmd)
            CMD_FRAME: begin
                n_last_angle = w_angle;
                n_primed     = 1'b1;
                n_status     = i_frame[STATUS_W-1:0];
                if (r_primed) begin
                    if (w_wrap_up) begin
                        if (r_turns != TURN_MAX) n_turns = r_turns + 1'b1;
                    end else if (w_wrap_dn) begin
                        if (r_turns != TURN_MIN) n_turns = r_turns - 1'b1;
                    end
                end
            end
            CMD_SET: begin
                n_primed = r_primed;
            end
            default: begin
                n_primed = r_primed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_primed     <= 1'b0;
            r_turns      <= '0;
            r_status     <= '0;
        end else if (w_accept) begin
            r_last_angle <= n_last_angle;
            r_primed     <= n_primed;
            r_turns      <= n_turns;
            r_status     <= n_status;
        end
    end

    assign o_ready = !i_q_stat.full;
    assign o_push  = w_accept;
    assign o_entry = {i_desired, n_status, n_turns, n_last_angle, i_cmd};

endmodule

>>> design/mte_queue.sv
// Short register queue between the front end and the back end.
// Depends on mte_pkg for the status struct.
module mte_queue import mte_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) r_count <= r_count + 1'b1;
            else if (w_pop && !w_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

>>> design/mte_back.sv
// Back end of the encoder tracker: scaling pipeline, offset state and output register.
// Depends on mte_pkg; drains mte_queue.
module mte_back import mte_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int TURN_BITS  = TURN_BITS_DEF,
    localparam int ENTRY_W   = 1 + ANGLE_BITS + TURN_BITS + STATUS_W + DATA_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [GAIN_W-1:0]      i_gain,
    input  t_q_stat                i_q_stat,
    input  logic [ENTRY_W-1:0]     i_entry,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_ANGLE_W-1:0] o_angle,
    output logic [OUT_TURNS_W-1:0] o_turns,
    output logic [DATA_W-1:0]      o_position,
    output logic [STATUS_W-1:0]    o_status
);

    localparam int RAW_W  = TURN_BITS + ANGLE_BITS;
    localparam int LO_W   = (RAW_W + 1) / 2;
    localparam int HI_W   = RAW_W - LO_W;
    localparam int PL_W   = LO_W + GAIN_W;
    localparam int PH_W   = HI_W + GAIN_W;
    localparam int P_W    = RAW_W + GAIN_W;
    localparam int Q_W    = P_W - GAIN_FRAC;
    localparam int QX_W   = (Q_W > DATA_W + 1) ? Q_W : DATA_W + 1;
    localparam int TURN_LSB = 1 + ANGLE_BITS;
    localparam int STAT_LSB = TURN_LSB + TURN_BITS;
    localparam int DES_LSB  = STAT_LSB + STATUS_W;

    function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
        logic [DATA_W-1:0] res;
        if (v[DATA_W] != v[DATA_W-1]) res = v[DATA_W] ? POS_MIN : POS_MAX;
        else res = v[DATA_W-1:0];
        return res;
    endfunction

    logic w_en;

    // Stage 1: magnitude of the signed multi-turn count.
    logic               r_v1, r_neg1;
    logic [RAW_W-1:0]   r_mag1;
    logic [ENTRY_W-1:0] r_e1;
    logic [RAW_W-1:0]   w_raw, w_mag;

    // Stage 2: two partial products against the gain.
    logic               r_v2, r_neg2;
    logic [PL_W-1:0]    r_pp_lo;
    logic [PH_W-1:0]    r_pp_hi;
    logic [ENTRY_W-1:0] r_e2;

    // Stage 3: product sum with the fraction dropped.
    logic               r_v3, r_neg3;
    logic [Q_W-1:0]     r_q3;
    logic [ENTRY_W-1:0] r_e3;
    logic [P_W-1:0]     w_prod;

    // Stage 4: saturation and state update.
    logic               r_v4;
    logic [DATA_W-1:0]  r_a4, r_b4;
    logic [ENTRY_W-1:0] r_e4;
    logic [DATA_W-1:0]  r_scaled, r_offset;
    logic [QX_W-1:0]    w_qx;
    logic               w_ovf;
    logic [DATA_W-1:0]  w_scaled, w_new_off;
    logic [DATA_W:0]    w_diff;

    // Output register.
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_pos;
    logic [ENTRY_W-1:0] r_out_e;
    logic [DATA_W:0]    w_sum;
    logic signed [TURN_BITS-1:0] w_out_turns;

    assign w_en  = !r_out_valid || i_ready;
    assign o_pop = w_en && !i_q_stat.empty;

    assign w_raw = i_entry[STAT_LSB-1:1];
    assign w_mag = w_raw[RAW_W-1] ? RAW_W'(-w_raw) : w_raw;

    assign w_prod = (P_W'(r_pp_hi) << LO_W) + P_W'(r_pp_lo);

    assign w_qx  = QX_W'(r_q3);
    assign w_ovf = |w_qx[QX_W-1:DATA_W-1];
    always_comb begin
        if (r_neg3) w_scaled = w_ovf ? POS_MIN : DATA_W'(-w_qx[DATA_W-1:0]);
        else w_scaled = w_ovf ? POS_MAX : w_qx[DATA_W-1:0];
    end
    assign w_diff    = {r_e3[ENTRY_W-1], r_e3[ENTRY_W-1:DES_LSB]} -
                       {r_scaled[DATA_W-1], r_scaled};
    assign w_new_off = sat33(w_diff);
    assign w_sum     = {r_a4[DATA_W-1], r_a4} + {r_b4[DATA_W-1], r_b4};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            r_scaled    <= '0;
            r_offset    <= '0;
        end else if (w_en) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
            if (r_v3) begin
                case (r_e3[0])
                    CMD_FRAME: r_scaled <= w_scaled;
                    CMD_SET:   r_offset <= w_new_off;
                    default:   r_offset <= r_offset;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1     <= i_entry;
            r_neg1   <= w_raw[RAW_W-1];
            r_mag1   <= w_mag;
            r_e2     <= r_e1;
            r_neg2   <= r_neg1;
            r_pp_lo  <= PL_W'(r_mag1[LO_W-1:0]) * PL_W'(i_gain);
            r_pp_hi  <= PH_W'(r_mag1[RAW_W-1:LO_W]) * PH_W'(i_gain);
            r_e3     <= r_e2;
            r_neg3   <= r_neg2;
            r_q3     <= w_prod[P_W-1:GAIN_FRAC];
            r_e4     <= r_e3;
            // The pair summed at the output is the state as this item leaves it.
            case (r_e3[0])
                CMD_FRAME: begin
                    r_a4 <= w_scaled;
                    r_b4 <= r_offset;
                end
                CMD_SET: begin
                    r_a4 <= r_scaled;
                    r_b4 <= w_new_off;
                end
                default: begin
                    r_a4 <= r_scaled;
                    r_b4 <= r_offset;
                end
            endcase
            r_out_e   <= r_e4;
            r_out_pos <= sat33(w_sum);
        end
    end

    assign w_out_turns = r_out_e[STAT_LSB-1:TURN_LSB];
    assign o_valid     = r_out_valid;
    assign o_angle     = OUT_ANGLE_W'(r_out_e[TURN_LSB-1:1]);
    assign o_turns     = OUT_TURNS_W'(w_out_turns);
    assign o_position  = r_out_pos;
    assign o_status    = r_out_e[DES_LSB-1:STAT_LSB];

endmodule

>>> design/multiturn_encoder_tracker.sv
// Multi-turn absolute encoder tracker, top level.
// Throughput: one item per cycle while the output side does not stall, set by the
// five-register back-end pipeline that holds the gain multiply and the offset adder.
// Reset (synchronous, active low) restores the register defaults and clears all
// tracking state; no clearing pass follows, the block is ready the next cycle.
module multiturn_encoder_tracker import mte_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int TURN_BITS  = TURN_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port: gain, wrap high and wrap low thresholds.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [GAIN_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, from bit 0 up: frame[17:0], desired_position[49:18], zero pad[55:50].
    input  logic [55:0]           s_axis_tdata,
    // tuser: cmd (0 sensor frame, 1 set position).
    input  logic                  s_axis_tuser,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, from bit 0 up: angle[11:0], turns[27:12], position[59:28],
    // field_state[61:60], linearity_alarm[62], cordic_overflow[63],
    // startup_done[64], zero pad[71:65].
    output logic [71:0]           m_axis_tdata
);

    localparam int ENTRY_W = 1 + ANGLE_BITS + TURN_BITS + STATUS_W + DATA_W;

    // Configuration registers. Write only while the pipeline is empty (the
    // block does not enforce it), for stable thresholds and gain per item.
    t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GAIN:      n_cfg.gain      = i_cfg_wdata;
                CFG_WRAP_HIGH: n_cfg.wrap_high = i_cfg_wdata[WRAP_W-1:0];
                CFG_WRAP_LOW:  n_cfg.wrap_low  = i_cfg_wdata[WRAP_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain      <= GAIN_RESET;
            r_cfg.wrap_high <= WRAP_HIGH_RESET;
            r_cfg.wrap_low  <= WRAP_LOW_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The front end does the turn unwrapping in the cycle of the transfer and
    // pushes a complete work entry; the queue lets it keep accepting while the
    // back end is held by a stalled output.
    logic               w_push, w_pop;
    logic [ENTRY_W-1:0] w_push_entry, w_pop_entry;
    t_q_stat            w_q_stat;
    logic [STATUS_W-1:0] w_status;
    logic [OUT_ANGLE_W-1:0] w_angle;
    logic [OUT_TURNS_W-1:0] w_turns;
    logic [DATA_W-1:0]      w_position;

    mte_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .TURN_BITS  (TURN_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .i_cmd     (s_axis_tuser),
        .i_frame   (s_axis_tdata[FRAME_W-1:0]),
        .i_desired (s_axis_tdata[FRAME_W+DATA_W-1:FRAME_W]),
        .i_q_stat  (w_q_stat),
        .o_ready   (s_axis_tready),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    mte_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .i_pop   (w_pop),
        .o_data  (w_pop_entry),
        .o_stat  (w_q_stat)
    );

    // The back end scales by the gain, keeps the scaled position and offset,
    // and holds the finished result in its output register.
    mte_back #(
        .ANGLE_BITS (ANGLE_BITS),
        .TURN_BITS  (TURN_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_gain     (r_cfg.gain),
        .i_q_stat   (w_q_stat),
        .i_entry    (w_pop_entry),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_angle    (w_angle),
        .o_turns    (w_turns),
        .o_position (w_position),
        .o_status   (w_status)
    );

    // Status bit zero of the sensor frame is not reported.
    assign m_axis_tdata = {7'd0, w_status[STATUS_W-1:1], w_position, w_turns, w_angle};

endmodule

>>> sim/multiturn_encoder_tracker_tb.sv
// Self-checking testbench for the multi-turn encoder tracker. Drives the frame/set
// stream and the register port, and checks every output transfer against a table
// reading or a behavioral tracker model here; depends on mte_pkg and the RTL only.
`timescale 1ns / 100ps

module multiturn_encoder_tracker_tb;
    import mte_pkg::*;

    localparam int TURN_TOP    = 32767;
    localparam int TURN_BOTTOM = -32768;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 150;

    // One output reading, split into the fields of the output tdata word.
    typedef struct packed {
        logic [11:0] angle;
        logic [15:0] turns;
        logic [31:0] position;
        logic [1:0]  field_state;
        logic        linearity_alarm;
        logic        cordic_overflow;
        logic        startup_done;
    } t_reading;

    // One row of the directed table. Rows with hand_checked set carry a reading
    // that is obvious from the spec; the others are checked against the tracker model.
    typedef struct packed {
        logic        cmd;
        logic [17:0] frame;
        logic [31:0] desired;
        logic        hand_checked;
        t_reading    want;
    } t_stim_row;

    localparam t_reading NO_READ = '0;

    // Clock, reset and all block inputs start at known values.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_addr     = CFG_GAIN;
    logic [23:0] i_cfg_wdata    = '0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata   = '0;     // frame[17:0], desired_position[49:18], pad
    logic        s_axis_tuser   = CMD_FRAME; // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [71:0] m_axis_tdata;            // angle, turns, position, status flags, pad

    // Side channel that travels with the input transfer inside the testbench.
    logic     row_hand_checked = 1'b0;
    t_reading row_want         = '0;

    // Idle knobs for the current phase, in percent.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int unsigned cycle_count = 0;
    int          fail_count  = 0;

    // Rotating-shaft generator state for the random part.
    int spin_angle = 0;
    int spin_dir   = 1;

    // Tracker model: register copies and tracking state.
    logic [23:0] cfg_gain      = GAIN_RESET;
    logic [11:0] cfg_wrap_high = WRAP_HIGH_RESET;
    logic [11:0] cfg_wrap_low  = WRAP_LOW_RESET;
    logic [11:0] trk_last_angle = '0;
    logic        trk_primed     = 1'b0;
    int          trk_turns      = 0;
    int          trk_scaled     = 0;
    int          trk_offset     = 0;
    logic [5:0]  trk_status     = '0;

    t_reading expected_readings[$];

    multiturn_encoder_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Directed table, run right after reset with the register defaults
    // (unity gain, wrap thresholds 3900 and 195).
    t_stim_row dir_tab [0:17] = '{
        // First frame after reset never counts a turn; all status flags set.
        '{CMD_FRAME, {12'd4095, 6'b111111}, 32'd0, 1'b1,
          '{12'd4095, 16'd0, 32'd4095, 2'd3, 1'b1, 1'b1, 1'b1}},
        // Top to zero counts one turn up.
        '{CMD_FRAME, {12'd0, 6'b000000}, 32'hFFFF_FFFF, 1'b1,
          '{12'd0, 16'd1, 32'd4096, 2'd0, 1'b0, 1'b0, 1'b0}},
        // Zero back to the top counts one turn down; magnet far.
        '{CMD_FRAME, {12'd4000, 6'b000010}, 32'd0, 1'b1,
          '{12'd4000, 16'd0, 32'd4000, 2'd1, 1'b0, 1'b0, 1'b0}},
        '{CMD_FRAME, {12'd4000, 6'b000100}, 32'd0, 1'b0, NO_READ},
        // Just under the low threshold counts; exactly on it does not.
        '{CMD_FRAME, {12'd194, 6'b001000}, 32'd0, 1'b0, NO_READ},
        '{CMD_FRAME, {12'd195, 6'b010000}, 32'd0, 1'b0, NO_READ},
        '{CMD_FRAME, {12'd3901, 6'b100000}, 32'd0, 1'b0, NO_READ},
        // Status bit zero alone must not show up anywhere.
        '{CMD_FRAME, {12'd3900, 6'b000001}, 32'd0, 1'b0, NO_READ},
        '{CMD_FRAME, {12'd0, 6'b000000}, 32'd0, 1'b0, NO_READ},
        '{CMD_FRAME, {12'd4095, 6'b000000}, 32'd0, 1'b0, NO_READ},
        // Set commands ignore the frame; the most negative request cannot be
        // reached because the offset saturates.
        '{CMD_SET, 18'h3FFFF, 32'h7FFF_FFFF, 1'b1,
          '{12'd4095, 16'd0, 32'h7FFF_FFFF, 2'd0, 1'b0, 1'b0, 1'b0}},
        '{CMD_SET, 18'h3FFFF, 32'h8000_0000, 1'b1,
          '{12'd4095, 16'd0, 32'h8000_0FFF, 2'd0, 1'b0, 1'b0, 1'b0}},
        '{CMD_SET, 18'h00000, 32'd0, 1'b1,
          '{12'd4095, 16'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0}},
        '{CMD_FRAME, {12'd0, 6'b000000}, 32'd0, 1'b0, NO_READ},
        '{CMD_SET, 18'h2AAAA, 32'hFFFF_FFFF, 1'b0, NO_READ},
        '{CMD_FRAME, {12'd2048, 6'b101010}, 32'd0, 1'b0, NO_READ},
        '{CMD_FRAME, {12'd4095, 6'b010101}, 32'd0, 1'b0, NO_READ},
        '{CMD_FRAME, {12'd0, 6'b111111}, 32'd0, 1'b0, NO_READ}
    };

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Advances the tracker model by one accepted item and returns the reading
    // the block must produce for it.
    function automatic t_reading encoder_track(input logic cmd, input logic [17:0] frame,
                                               input logic signed [31:0] desired);
        logic [11:0] ang;
        longint      raw;
        longint      mag;
        longint      q;
        t_reading    r;
        if (cmd == CMD_FRAME) begin
            ang = frame[17:6];
            trk_status = frame[5:0];
            // Counting needs a previous angle, so the first frame only primes.
            if (trk_primed) begin
                if (trk_last_angle > cfg_wrap_high && ang < cfg_wrap_low) begin
                    if (trk_turns < TURN_TOP) trk_turns++;
                end else if (trk_last_angle < cfg_wrap_low && ang > cfg_wrap_high) begin
                    if (trk_turns > TURN_BOTTOM) trk_turns--;
                end
            end
            trk_primed = 1'b1;
            trk_last_angle = ang;
            // Scale the magnitude so the Q8.16 product truncates toward zero.
            raw = longint'(ang) + longint'(trk_turns) * 4096;
            mag = (raw < 0) ? -raw : raw;
            q = (mag * longint'(cfg_gain)) >>> GAIN_FRAC;
            trk_scaled = clamp32((raw < 0) ? -q : q);
        end else begin
            trk_offset = clamp32(longint'(desired) - longint'(trk_scaled));
        end
        r.angle           = trk_last_angle;
        r.turns           = trk_turns[15:0];
        r.position        = clamp32(longint'(trk_scaled) + longint'(trk_offset));
        r.field_state     = trk_status[2:1];
        r.linearity_alarm = trk_status[3];
        r.cordic_overflow = trk_status[4];
        r.startup_done    = trk_status[5];
        return r;
    endfunction

    task automatic note_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Scoreboard. Both sides are sampled at the rising edge, where every input
    // was set up at the preceding falling edge. The output transfer is checked
    // before the input transfer of the same edge is modeled; an item passes the
    // back-end registers first, so they never belong to the same item.
    always @(posedge i_clk) begin
        t_reading want;
        t_reading model;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    $error("output transfer with no reading outstanding");
                end else begin
                    want = expected_readings.pop_front();
                    note_field("angle", want.angle, m_axis_tdata[11:0]);
                    note_field("turns", $signed(want.turns), $signed(m_axis_tdata[27:12]));
                    note_field("position", $signed(want.position),
                               $signed(m_axis_tdata[59:28]));
                    note_field("field_state", want.field_state, m_axis_tdata[61:60]);
                    note_field("linearity_alarm", want.linearity_alarm, m_axis_tdata[62]);
                    note_field("cordic_overflow", want.cordic_overflow, m_axis_tdata[63]);
                    note_field("startup_done", want.startup_done, m_axis_tdata[64]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // The model runs for every item so its state stays in step,
                // even where the table supplies the reading by hand.
                model = encoder_track(s_axis_tuser, s_axis_tdata[17:0], s_axis_tdata[49:18]);
                expected_readings.push_back(row_hand_checked ? row_want : model);
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle at the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one item and returns at the falling edge after its transfer. Entered
    // and left at a falling edge, so tvalid stays high between back-to-back items.
    task automatic send_item(input logic cmd, input logic [17:0] frame,
                             input logic [31:0] desired, input logic hand_checked,
                             input t_reading want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid    <= 1'b1;
        s_axis_tuser     <= cmd;
        s_axis_tdata     <= {6'd0, desired, frame};
        row_hand_checked <= hand_checked;
        row_want         <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every outstanding reading has come back.
    // Always waits for a falling edge before it checks, so tvalid is not lowered
    // and raised within the same step.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_readings.size() != 0);
    endtask

    // Register write; only called while the block holds no items.
    task automatic program_reg(input t_cfg_idx idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_GAIN:      cfg_gain = val;
            CFG_WRAP_HIGH: cfg_wrap_high = val[11:0];
            CFG_WRAP_LOW:  cfg_wrap_low = val[11:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_target();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Random part: mostly a shaft turning in steps of up to 600 counts with
    // occasional reversals, which walks across the wrap in both directions;
    // the rest is angle jumps and set commands with random content.
    task automatic run_random(input int count);
        int roll;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 60) wait_drained();
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_item(CMD_SET, 18'($urandom), pick_target(), 1'b0, NO_READ);
            end else begin
                if (roll < 16) begin
                    spin_angle = $urandom_range(4095);
                end else begin
                    if ($urandom_range(24) == 0) spin_dir = -spin_dir;
                    spin_angle = (spin_angle + spin_dir * int'($urandom_range(600))) & 4095;
                end
                send_item(CMD_FRAME, {12'(spin_angle), 6'($urandom_range(63))}, $urandom,
                          1'b0, NO_READ);
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r])
            send_item(dir_tab[r].cmd, dir_tab[r].frame, dir_tab[r].desired,
                      dir_tab[r].hand_checked, dir_tab[r].want);
        wait_drained();

        // Four random phases, each with its own register setting and idle pattern.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    // Largest gain, default thresholds, no idling.
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    program_reg(CFG_GAIN, 24'hFF_FFFF);
                    program_reg(CFG_WRAP_HIGH, 24'd3900);
                    program_reg(CFG_WRAP_LOW, 24'd195);
                end
                1: begin
                    // Zero gain and thresholds that can never count a turn.
                    send_idle_pct = 77;
                    recv_stall_pct = 0;
                    program_reg(CFG_GAIN, 24'd0);
                    program_reg(CFG_WRAP_HIGH, 24'd4095);
                    program_reg(CFG_WRAP_LOW, 24'd0);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 77;
                    program_reg(CFG_GAIN, 24'($urandom_range(24'hFF_FFFF)));
                    program_reg(CFG_WRAP_HIGH, 24'($urandom_range(4095, 3500)));
                    program_reg(CFG_WRAP_LOW, 24'($urandom_range(600)));
                end
                default: begin
                    // Smallest nonzero gain; nearly every frame counts a turn.
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                    program_reg(CFG_GAIN, 24'd1);
                    program_reg(CFG_WRAP_HIGH, 24'd0);
                    program_reg(CFG_WRAP_LOW, 24'd4095);
                end
            endcase
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        // Set commands at both ends of the range and one random request.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(CMD_SET, 18'($urandom), 32'h7FFF_FFFF, 1'b0, NO_READ);
        send_item(CMD_SET, 18'($urandom), 32'h8000_0000, 1'b0, NO_READ);
        send_item(CMD_SET, 18'($urandom), $urandom, 1'b0, NO_READ);
        wait_drained();

        // Quiet period so that any stray output transfer is caught.
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && expected_readings.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
